/* design/bis_pkg.sv */
package bis_pkg;

  localparam int QUERY_W  = 24;
  localparam int START_W  = 16;
  localparam int VALUE_W  = 16;
  localparam int SIZE_W   = 8;
  localparam int INDEX_W  = 7;
  localparam int OUT_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WRAP    = 3'd0,
    REG_OUTSIDE = 3'd1,
    REG_START_R = 3'd2,
    REG_START_C = 3'd3,
    REG_ROWS    = 3'd4,
    REG_COLS    = 3'd5
  } cfg_reg_t;

endpackage

/* design/bis_axis.sv */
module bis_axis #(
  parameter int MAX_DIM   = 128,
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic signed [bis_pkg::QUERY_W-1:0]   coord,
  input  logic signed [bis_pkg::START_W-1:0]   start,
  input  logic        [bis_pkg::SIZE_W-1:0]    size_raw,
  input  logic                                 wrap,
  output logic                                 ok,
  output logic        [$clog2(MAX_DIM)-1:0]    lo,
  output logic        [$clog2(MAX_DIM)-1:0]    hi,
  output logic        [FRAC_BITS-1:0]          frac
);

  localparam int AW  = $clog2(MAX_DIM);
  localparam int SZW = $clog2(MAX_DIM + 1);
  localparam int FLW = bis_pkg::QUERY_W - FRAC_BITS;
  localparam int DW  = ((FLW > bis_pkg::START_W) ? FLW : bis_pkg::START_W) + 2;
  localparam logic signed [DW-1:0] ONE = DW'(1);
  localparam logic signed [DW-1:0] TWO = DW'(2);

  logic signed [bis_pkg::QUERY_W-1:0] fl;
  logic signed [DW-1:0]               d_nxt;
  logic signed [DW-1:0]               d_r;
  logic        [FRAC_BITS-1:0]        frac_r;
  logic        [SZW-1:0]              size_eff;
  logic signed [DW-1:0]               szd;
  logic signed [DW-1:0]               a;
  logic signed [DW-1:0]               b;
  logic signed [DW-1:0]               aw;
  logic signed [DW-1:0]               bw;

  assign fl    = coord >>> FRAC_BITS;
  assign d_nxt = DW'(fl) - DW'(start);

  always_ff @(posedge clk) begin
    if (load) begin
      d_r    <= d_nxt;
      frac_r <= coord[FRAC_BITS-1:0];
    end
  end

  always_comb begin
    if (32'(size_raw) < 32'd2) begin
      size_eff = SZW'(2);
    end else if (32'(size_raw) > 32'(MAX_DIM)) begin
      size_eff = SZW'(MAX_DIM);
    end else begin
      size_eff = SZW'(size_raw);
    end
  end

  assign szd = DW'($signed({1'b0, size_eff}));
  assign a   = d_r;
  assign b   = d_r + ONE;

  always_comb begin
    aw = a;
    bw = b;
    if (a[DW-1]) begin
      aw = a + szd;
    end else if (a > szd - ONE) begin
      aw = a - szd;
    end
    if (b[DW-1]) begin
      bw = b + szd;
    end else if (b > szd - ONE) begin
      bw = b - szd;
    end
    if (wrap) begin
      ok = !aw[DW-1] && (aw <= szd - ONE) && !bw[DW-1] && (bw <= szd - ONE);
    end else begin
      ok = !d_r[DW-1] && (d_r <= szd - TWO);
    end
  end

  assign lo   = aw[AW-1:0];
  assign hi   = bw[AW-1:0];
  assign frac = frac_r;

endmodule

/* design/bilinear_image_sampler.sv */
// Channel  | Direction | Handshake          | Payload
// in_      | input     | in_valid/in_ready  | cmd, write row/col/value, query row/col
// out_     | output    | out_valid/out_ready| sample_out, was_outside
// cfg_     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// One item per cycle unless output stalls; queries pass d_r, p*_r, a*_r, v_r, out_*.
// Two image copies with two read ports each deliver all four neighbors together.
// Write items update the store at acceptance and produce no result.
// Reset is synchronous and clears control state; the image store is not cleared.
// Each stage stalls only when its successor is full and stalled.
module bilinear_image_sampler #(
  parameter int MAX_DIM     = 128,
  parameter int FRAC_BITS   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic                                    in_cmd,
  input  logic        [bis_pkg::INDEX_W-1:0]      in_write_row,
  input  logic        [bis_pkg::INDEX_W-1:0]      in_write_col,
  input  logic signed [bis_pkg::VALUE_W-1:0]      in_write_value,
  input  logic signed [bis_pkg::QUERY_W-1:0]      in_query_row,
  input  logic signed [bis_pkg::QUERY_W-1:0]      in_query_col,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [bis_pkg::OUT_W-1:0]        out_sample_out,
  output logic                                    out_was_outside,
  input  logic                                    cfg_wr_en,
  input  logic        [bis_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic        [bis_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW     = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * AW;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int SB     = SAMPLE_BITS;
  localparam int F      = FRAC_BITS;
  localparam int AW3    = SB + F + 2;
  localparam int VW     = SB + 2 * F + 4;
  localparam int RW     = VW + 16;
  localparam int LSH    = (2 * F < 16) ? (16 - 2 * F) : 0;
  localparam int RSH    = (2 * F >= 16) ? (2 * F - 16) : 0;
  localparam int RND    = (RSH > 0) ? (1 << (RSH - 1)) : 0;
  localparam logic signed [RW-1:0] RND_C = RW'(RND);

  logic                                 wrap_r;
  logic signed [bis_pkg::START_W-1:0]   outside_r;
  logic signed [bis_pkg::START_W-1:0]   start_row_r;
  logic signed [bis_pkg::START_W-1:0]   start_col_r;
  logic        [bis_pkg::SIZE_W-1:0]    rows_r;
  logic        [bis_pkg::SIZE_W-1:0]    cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_r      <= 1'b0;
      outside_r   <= '0;
      start_row_r <= '0;
      start_col_r <= '0;
      rows_r      <= bis_pkg::SIZE_W'(128);
      cols_r      <= bis_pkg::SIZE_W'(128);
    end else if (cfg_wr_en) begin
      unique case (bis_pkg::cfg_reg_t'(cfg_index))
        bis_pkg::REG_WRAP:    wrap_r      <= cfg_wdata[0];
        bis_pkg::REG_OUTSIDE: outside_r   <= $signed(cfg_wdata);
        bis_pkg::REG_START_R: start_row_r <= $signed(cfg_wdata);
        bis_pkg::REG_START_C: start_col_r <= $signed(cfg_wdata);
        bis_pkg::REG_ROWS:    rows_r      <= cfg_wdata[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_COLS:    cols_r      <= cfg_wdata[bis_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic r1, r2, r3, r4, r_out;

  assign r_out    = !out_valid_r || out_ready;
  assign r4       = !v4_r || r_out;
  assign r3       = !v3_r || r4;
  assign r2       = !v2_r || r3;
  assign r1       = !v1_r || r2;
  assign in_ready = r1;

  logic in_acc, q_acc, wr_en;
  logic [31:0]        wr_row_ext, wr_col_ext;
  logic [ADDR_W-1:0]  wr_addr;
  logic [SB-1:0]      wr_data;

  assign in_acc     = in_valid && in_ready;
  assign q_acc      = in_acc && (in_cmd == bis_pkg::CMD_QUERY);
  assign wr_row_ext = 32'(in_write_row);
  assign wr_col_ext = 32'(in_write_col);
  assign wr_en      = in_acc && (in_cmd == bis_pkg::CMD_WRITE)
                   && (wr_row_ext < 32'(MAX_DIM)) && (wr_col_ext < 32'(MAX_DIM));
  assign wr_addr    = {wr_row_ext[AW-1:0], wr_col_ext[AW-1:0]};
  assign wr_data    = SB'($unsigned(in_write_value));

  logic          ok_row, ok_col;
  logic [AW-1:0] r0, r1i, c0, c1i;
  logic [F-1:0]  fr1, fc1;

  bis_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_row (
    .clk(clk), .load(q_acc), .coord(in_query_row), .start(start_row_r),
    .size_raw(rows_r), .wrap(wrap_r), .ok(ok_row), .lo(r0), .hi(r1i), .frac(fr1)
  );

  bis_axis #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_col (
    .clk(clk), .load(q_acc), .coord(in_query_col), .start(start_col_r),
    .size_raw(cols_r), .wrap(wrap_r), .ok(ok_col), .lo(c0), .hi(c1i), .frac(fc1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (r1) begin
      v1_r <= q_acc;
    end
  end

  // Each copy holds the whole image; copy A serves the low row, copy B the high row.
  logic [SB-1:0] mem_a [DEPTH];
  logic [SB-1:0] mem_b [DEPTH];
  logic signed [SB-1:0] p00_r, p01_r, p10_r, p11_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (r2) begin
      p00_r <= $signed(mem_a[{r0, c0}]);
      p01_r <= $signed(mem_a[{r0, c1i}]);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (r2) begin
      p10_r <= $signed(mem_b[{r1i, c0}]);
      p11_r <= $signed(mem_b[{r1i, c1i}]);
    end
  end

  logic         outs2_r, outs3_r, outs4_r;
  logic [F-1:0] fr2_r, fc2_r, fr3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (r2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      outs2_r <= !(ok_row && ok_col);
      fr2_r   <= fr1;
      fc2_r   <= fc1;
    end
  end

  logic signed [SB:0]    diff0, diff1;
  logic signed [AW3-1:0] fc_s;
  logic signed [AW3-1:0] a0_nxt, a1_nxt, a0_r, a1_r;

  assign diff0  = (SB + 1)'(p01_r) - (SB + 1)'(p00_r);
  assign diff1  = (SB + 1)'(p11_r) - (SB + 1)'(p10_r);
  assign fc_s   = AW3'($signed({1'b0, fc2_r}));
  assign a0_nxt = (AW3'(p00_r) <<< F) + AW3'(diff0) * fc_s;
  assign a1_nxt = (AW3'(p10_r) <<< F) + AW3'(diff1) * fc_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (r3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r3) begin
      a0_r    <= a0_nxt;
      a1_r    <= a1_nxt;
      fr3_r   <= fr2_r;
      outs3_r <= outs2_r;
    end
  end

  logic signed [AW3:0]  dv;
  logic signed [VW-1:0] v_nxt, v_r;

  assign dv    = (AW3 + 1)'(a1_r) - (AW3 + 1)'(a0_r);
  assign v_nxt = (VW'(a0_r) <<< F) + VW'(dv) * VW'($signed({1'b0, fr3_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (r4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r4) begin
      v_r     <= v_nxt;
      outs4_r <= outs3_r;
    end
  end

  logic signed [RW-1:0]            t_w, res_w;
  logic signed [bis_pkg::OUT_W-1:0] sat_w, out_nxt;
  logic                             fits;

  assign t_w   = (RW'(v_r) <<< LSH) + RND_C;
  assign res_w = t_w >>> RSH;
  assign fits  = (res_w[RW-1:bis_pkg::OUT_W-1] == '0) || (res_w[RW-1:bis_pkg::OUT_W-1] == '1);

  always_comb begin
    if (fits) begin
      sat_w = res_w[bis_pkg::OUT_W-1:0];
    end else if (res_w[RW-1]) begin
      sat_w = {1'b1, {(bis_pkg::OUT_W - 1){1'b0}}};
    end else begin
      sat_w = {1'b0, {(bis_pkg::OUT_W - 1){1'b1}}};
    end
    if (outs4_r) begin
      out_nxt = {outside_r, 16'h0000};
    end else begin
      out_nxt = sat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (r_out) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (r_out) begin
      out_sample_out  <= out_nxt;
      out_was_outside <= outs4_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/bis_checker.sv */
module bis_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  in_cmd,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [bis_pkg::OUT_W-1:0]      out_sample_out,
  input logic                                  out_was_outside
);

  logic q_acc;

  assign q_acc = in_valid && in_ready && (in_cmd == bis_pkg::CMD_QUERY);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
      && $stable(out_was_outside))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  a_outside_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_outside |-> out_sample_out[15:0] == 16'h0000)
    else $error("outside result carries fraction bits");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    q_acc ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("query result missing after free-flowing pipeline");

endmodule

bind bilinear_image_sampler bis_checker u_bis_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .in_cmd(in_cmd),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_sample_out(out_sample_out),
  .out_was_outside(out_was_outside)
);
